FILE: rtl/msc_pkg.sv
package msc_pkg;

    // Scan phases
    localparam int PH_W = 4;
    localparam logic [PH_W-1:0] PH_HDR0  = 4'd0;
    localparam logic [PH_W-1:0] PH_HDR1  = 4'd1;
    localparam logic [PH_W-1:0] PH_HDR2  = 4'd2;
    localparam logic [PH_W-1:0] PH_HDR3  = 4'd3;
    localparam logic [PH_W-1:0] PH_BODY  = 4'd4;
    localparam logic [PH_W-1:0] PH_ZERO1 = 4'd5;
    localparam logic [PH_W-1:0] PH_ZERO2 = 4'd6;
    localparam logic [PH_W-1:0] PH_CODE  = 4'd7;
    localparam logic [PH_W-1:0] PH_HALT  = 4'd8;

    // Result kinds
    localparam logic [1:0] KIND_BYTE   = 2'd0;
    localparam logic [1:0] KIND_MARKER = 2'd1;
    localparam logic [1:0] KIND_ERROR  = 2'd2;

    // Result actions inside one item
    localparam logic [1:0] ACT_BYTE = 2'd0;
    localparam logic [1:0] ACT_MARK = 2'd1;
    localparam logic [1:0] ACT_ERR  = 2'd2;

    // Stream byte values and start codes
    localparam logic [7:0] BYTE_ZERO     = 8'h00;
    localparam logic [7:0] BYTE_ONE      = 8'h01;
    localparam logic [7:0] CODE_VOS      = 8'hB0;
    localparam logic [7:0] CODE_VO       = 8'hB5;
    localparam logic [7:0] CODE_VOP      = 8'hB6;
    localparam logic [7:0] CODE_VOL_LAST = 8'h1F;
    localparam logic [7:0] CODE_VL_FIRST = 8'h20;
    localparam logic [7:0] CODE_VL_LAST  = 8'h2F;

    // Sizes
    localparam int LENGTH_BITS_DEF = 16;
    localparam int LEN_OUT_W       = 16;
    localparam int SUB_W           = 3;   // up to five results per item
    localparam int VOP_POS         = 4;   // byte holding the coding type

    typedef struct packed {
        logic       command;
        logic [7:0] data_byte;
    } t_in_item;

    typedef struct packed {
        logic [1:0]           kind;
        logic [7:0]           out_byte;
        logic                 object_start;
        logic [7:0]           object_code;
        logic                 is_config;
        logic                 is_vop;
        logic [2:0]           coding_type;
        logic [LEN_OUT_W-1:0] object_length;
        logic                 config_before_first_vop;
        logic                 last;
    } t_out_item;

    // One result step of the item under work
    typedef struct packed {
        logic [SUB_W-1:0] num;
        logic [1:0]       act;
        logic [7:0]       value;
        logic             start;
        logic             new_obj;
        logic [7:0]       new_code;
        logic             last;
        logic [PH_W-1:0]  next_phase;
    } t_action;

    function automatic logic code_is_config(input logic [7:0] c);
        return (c == CODE_VOS) || (c == CODE_VO) || (c <= CODE_VOL_LAST)
            || ((c >= CODE_VL_FIRST) && (c <= CODE_VL_LAST));
    endfunction

endpackage

FILE: rtl/msc_stream_if.sv
interface msc_stream_if #(
    parameter type t_payload = logic
);
    logic     valid;
    logic     ready;
    t_payload payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

FILE: rtl/msc_decode.sv
module msc_decode (
    input  logic [msc_pkg::PH_W-1:0]  i_phase,
    input  msc_pkg::t_in_item         i_item,
    input  logic [msc_pkg::SUB_W-1:0] i_sub,
    output msc_pkg::t_action          o_action
);
    import msc_pkg::*;

    t_action    a;
    logic [7:0] b;

    assign b = i_item.data_byte;

    // Pick the result list of the item and the step at i_sub
    always_comb begin
        a            = '0;
        a.act        = ACT_BYTE;
        a.value      = BYTE_ZERO;
        a.new_code   = b;
        a.next_phase = i_phase;
        if (i_item.command) begin
            unique case (i_phase)
                PH_HDR0, PH_HDR1, PH_HDR2, PH_HDR3: begin
                    a.num        = SUB_W'(1);
                    a.act        = ACT_ERR;
                    a.next_phase = PH_HALT;
                end
                PH_BODY, PH_CODE: begin
                    a.num        = SUB_W'(1);
                    a.act        = ACT_MARK;
                    a.next_phase = PH_HALT;
                end
                PH_ZERO1: begin
                    a.num        = SUB_W'(2);
                    a.act        = (i_sub == SUB_W'(1)) ? ACT_MARK : ACT_BYTE;
                    a.next_phase = PH_HALT;
                end
                PH_ZERO2: begin
                    a.num        = SUB_W'(3);
                    a.act        = (i_sub == SUB_W'(2)) ? ACT_MARK : ACT_BYTE;
                    a.next_phase = PH_HALT;
                end
                default: begin
                    a.next_phase = PH_HALT;
                end
            endcase
        end else begin
            unique case (i_phase)
                PH_HDR0, PH_HDR1: begin
                    if (b != BYTE_ZERO) begin
                        a.num        = SUB_W'(1);
                        a.act        = ACT_ERR;
                        a.next_phase = PH_HALT;
                    end else begin
                        a.next_phase = (i_phase == PH_HDR0) ? PH_HDR1 : PH_HDR2;
                    end
                end
                PH_HDR2: begin
                    if (b != BYTE_ONE) begin
                        a.num        = SUB_W'(1);
                        a.act        = ACT_ERR;
                        a.next_phase = PH_HALT;
                    end else begin
                        a.next_phase = PH_HDR3;
                    end
                end
                PH_HDR3: begin
                    a.num        = SUB_W'(4);
                    a.value      = (i_sub == SUB_W'(2)) ? BYTE_ONE :
                                   (i_sub == SUB_W'(3)) ? b : BYTE_ZERO;
                    a.start      = (i_sub == SUB_W'(0));
                    a.new_obj    = (i_sub == SUB_W'(0));
                    a.next_phase = PH_BODY;
                end
                PH_BODY: begin
                    if (b == BYTE_ZERO) begin
                        a.next_phase = PH_ZERO1;
                    end else begin
                        a.num   = SUB_W'(1);
                        a.value = b;
                    end
                end
                PH_ZERO1: begin
                    if (b == BYTE_ZERO) begin
                        a.next_phase = PH_ZERO2;
                    end else begin
                        a.num        = SUB_W'(2);
                        a.value      = (i_sub == SUB_W'(1)) ? b : BYTE_ZERO;
                        a.next_phase = PH_BODY;
                    end
                end
                PH_ZERO2: begin
                    if (b == BYTE_ONE) begin
                        a.next_phase = PH_CODE;
                    end else begin
                        a.num        = SUB_W'(3);
                        a.value      = (i_sub == SUB_W'(2)) ? b : BYTE_ZERO;
                        a.next_phase = PH_BODY;
                    end
                end
                PH_CODE: begin
                    // close the old object, then open the new one
                    a.num        = SUB_W'(5);
                    a.act        = (i_sub == SUB_W'(0)) ? ACT_MARK : ACT_BYTE;
                    a.value      = (i_sub == SUB_W'(3)) ? BYTE_ONE :
                                   (i_sub == SUB_W'(4)) ? b : BYTE_ZERO;
                    a.start      = (i_sub == SUB_W'(1));
                    a.new_obj    = (i_sub == SUB_W'(1));
                    a.next_phase = PH_BODY;
                end
                default: begin
                    a.next_phase = PH_HALT;
                end
            endcase
        end
        a.last = (a.num != '0) && (i_sub == a.num - SUB_W'(1));
    end

    assign o_action = a;

endmodule

FILE: rtl/msc_track.sv
module msc_track #(
    parameter int LENGTH_BITS = msc_pkg::LENGTH_BITS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  msc_pkg::t_action         i_action,
    input  logic                     i_fire,
    input  logic                     i_done,
    output logic [msc_pkg::PH_W-1:0] o_phase,
    output msc_pkg::t_out_item       o_result
);
    import msc_pkg::*;

    localparam int WIDE_W = LENGTH_BITS + LEN_OUT_W;

    logic [PH_W-1:0]        r_phase;
    logic [7:0]             r_code, n_code;
    logic [LENGTH_BITS-1:0] r_count, n_count;
    logic [2:0]             r_vtype, n_vtype;
    logic                   r_vseen, n_vseen;
    logic [WIDE_W-1:0]      count_wide;
    logic [LEN_OUT_W-1:0]   len_sat;
    t_out_item              res;

    // Object state after a byte step (new object opens on its first byte)
    always_comb begin
        n_code  = i_action.new_obj ? i_action.new_code : r_code;
        n_vseen = r_vseen | (i_action.new_obj && (i_action.new_code == CODE_VOP));
        if (i_action.new_obj) begin
            n_count = LENGTH_BITS'(1);
            n_vtype = 3'd0;
        end else begin
            n_count = (r_count == '1) ? r_count : r_count + LENGTH_BITS'(1);
            n_vtype = r_vtype;
            if ((r_count == LENGTH_BITS'(VOP_POS)) && (r_code == CODE_VOP)) begin
                n_vtype = {1'b0, i_action.value[7:6]} + 3'd1;
            end
        end
    end

    // Saturate the length to the output field
    assign count_wide = {{LEN_OUT_W{1'b0}}, r_count};
    assign len_sat = (count_wide > WIDE_W'({LEN_OUT_W{1'b1}})) ? {LEN_OUT_W{1'b1}}
                                                              : count_wide[LEN_OUT_W-1:0];

    // Format the result of this step
    always_comb begin
        res      = '0;
        res.last = i_action.last;
        unique case (i_action.act)
            ACT_BYTE: begin
                res.kind         = KIND_BYTE;
                res.out_byte     = i_action.value;
                res.object_start = i_action.start;
                res.object_code  = n_code;
                res.is_config    = code_is_config(n_code);
                res.is_vop       = (n_code == CODE_VOP);
                res.coding_type  = n_vtype;
            end
            ACT_MARK: begin
                res.kind                    = KIND_MARKER;
                res.object_code             = r_code;
                res.is_config               = code_is_config(r_code);
                res.is_vop                  = (r_code == CODE_VOP);
                res.coding_type             = r_vtype;
                res.object_length           = len_sat;
                res.config_before_first_vop = code_is_config(r_code) && !r_vseen;
            end
            default: begin
                res.kind = KIND_ERROR;
            end
        endcase
    end

    // Advance object state per byte, phase per finished item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HDR0;
            r_code  <= '0;
            r_count <= '0;
            r_vtype <= '0;
            r_vseen <= 1'b0;
        end else begin
            if (i_fire && (i_action.act == ACT_BYTE)) begin
                r_code  <= n_code;
                r_count <= n_count;
                r_vtype <= n_vtype;
                r_vseen <= n_vseen;
            end
            if (i_done) begin
                r_phase <= i_action.next_phase;
            end
        end
    end

    assign o_phase  = r_phase;
    assign o_result = res;

endmodule

FILE: rtl/mpeg4_start_code_splitter_unit.sv
// An item waits in the input stage; each of its results goes to the result register.
// Throughput: one item per cycle when it gives at most one result and o_out does not stall;
// an item with n results stays in the input stage, one result per cycle while o_out is free.
// Reset (i_rst_n low at a clock edge) clears both stages and the scan state; after
// end of stream or a bad header the block ignores all items until reset.
module mpeg4_start_code_splitter_unit #(
    parameter int LENGTH_BITS = msc_pkg::LENGTH_BITS_DEF
) (
    input logic         i_clk,
    input logic         i_rst_n,
    msc_stream_if.sink   i_in,
    msc_stream_if.source o_out
);
    import msc_pkg::*;

    logic             r_in_vld;
    t_in_item         r_in;
    logic [SUB_W-1:0] r_sub;
    logic             r_out_vld;
    t_out_item        r_out;

    logic [PH_W-1:0]  phase;
    t_action          action;
    t_out_item        result;
    logic             out_free;
    logic             emit;
    logic             done;
    logic             take;

    msc_decode u_decode (
        .i_phase  (phase),
        .i_item   (r_in),
        .i_sub    (r_sub),
        .o_action (action)
    );

    msc_track #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_track (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_action (action),
        .i_fire   (emit),
        .i_done   (done),
        .o_phase  (phase),
        .o_result (result)
    );

    // Step handshake between input stage and result register
    assign out_free   = !r_out_vld || o_out.ready;
    assign emit       = r_in_vld && (action.num != '0) && out_free;
    assign done       = r_in_vld && ((action.num == '0) || (emit && action.last));
    assign take       = i_in.valid && i_in.ready;
    assign i_in.ready = !r_in_vld || done;

    // Hold the item under work and its result index
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
            r_sub    <= '0;
        end else begin
            if (take) begin
                r_in_vld <= 1'b1;
            end else if (done) begin
                r_in_vld <= 1'b0;
            end
            if (done) begin
                r_sub <= '0;
            end else if (emit) begin
                r_sub <= r_sub + SUB_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_in <= i_in.payload;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (emit) begin
            r_out_vld <= 1'b1;
        end else if (o_out.ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out <= result;
        end
    end

    assign o_out.valid   = r_out_vld;
    assign o_out.payload = r_out;

endmodule

FILE: dv/tb.sv
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import msc_pkg::*;

    localparam int LEN_BITS     = LENGTH_BITS_DEF;
    localparam int RAND_ITEMS   = 135;
    localparam int DRAIN_CYCLES = 8;
    localparam int TIMEOUT_NS   = 4_000_000;
    localparam int LONG_BODY    = 40;

    logic i_clk;
    logic i_rst_n;

    // Driven copies of the channel controls, known from time zero
    logic      in_valid;
    t_in_item  in_item;
    logic      out_ready = 1'b0;

    msc_stream_if #(.t_payload(t_in_item))  in_if ();
    msc_stream_if #(.t_payload(t_out_item)) out_if ();

    assign in_if.valid   = in_valid;
    assign in_if.payload = in_item;
    assign out_if.ready  = out_ready;

    mpeg4_start_code_splitter_unit #(
        .LENGTH_BITS(LEN_BITS)
    ) u_top (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_if),
        .o_out  (out_if)
    );

    // Predicted splitter state
    logic [PH_W-1:0]     scan_ph;
    logic [7:0]          cur_code;
    logic [LEN_BITS-1:0] obj_len;
    logic [2:0]          vop_coding;
    logic                vop_begun;
    logic                halted;

    t_out_item step_q[$];
    t_out_item pending_q[$];

    int  n_fail;
    int  n_sent;
    int  n_results;
    int  n_markers;
    int  n_errors;
    bit  burst;

    initial i_clk = 1'b0;
    always #1 i_clk = ~i_clk;

    function automatic logic config_code(input logic [7:0] c);
        return (c == CODE_VOS) || (c == CODE_VO) || (c <= CODE_VOL_LAST)
            || ((c >= CODE_VL_FIRST) && (c <= CODE_VL_LAST));
    endfunction

    // Short gaps mostly, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (burst || r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    task automatic add_result(input logic [1:0] kind, input logic [7:0] b,
                              input logic start, input logic [LEN_BITS-1:0] len,
                              input logic cfb, input logic err);
        t_out_item r;
        r.kind                    = kind;
        r.out_byte                = b;
        r.object_start            = start;
        r.object_code             = err ? BYTE_ZERO : cur_code;
        r.is_config               = !err && config_code(cur_code);
        r.is_vop                  = !err && (cur_code == CODE_VOP);
        r.coding_type             = err ? 3'd0 : vop_coding;
        r.object_length           = LEN_OUT_W'(len);
        r.config_before_first_vop = cfb;
        r.last                    = 1'b0;
        step_q.push_back(r);
    endtask

    task automatic emit_obj_byte(input logic [7:0] b, input logic start);
        // Byte four of a VOP carries the coding type in its top two bits
        if (obj_len == LEN_BITS'(VOP_POS) && cur_code == CODE_VOP)
            vop_coding = {1'b0, b[7:6]} + 3'd1;
        if (obj_len != '1) obj_len++;
        add_result(KIND_BYTE, b, start, '0, 1'b0, 1'b0);
    endtask

    task automatic emit_end_marker();
        add_result(KIND_MARKER, BYTE_ZERO, 1'b0, obj_len,
                   config_code(cur_code) && !vop_begun, 1'b0);
    endtask

    task automatic open_object(input logic [7:0] code);
        cur_code   = code;
        obj_len    = '0;
        vop_coding = 3'd0;
        if (code == CODE_VOP) vop_begun = 1'b1;
        emit_obj_byte(BYTE_ZERO, 1'b1);
        emit_obj_byte(BYTE_ZERO, 1'b0);
        emit_obj_byte(BYTE_ONE, 1'b0);
        emit_obj_byte(code, 1'b0);
    endtask

    task automatic reject_stream();
        add_result(KIND_ERROR, BYTE_ZERO, 1'b0, '0, 1'b0, 1'b1);
        halted  = 1'b1;
        scan_ph = PH_HALT;
    endtask

    // Work out the results of one accepted item and queue them
    task automatic predict_split(input t_in_item it);
        t_out_item t;
        logic [7:0] b;
        b = it.data_byte;
        step_q.delete();
        if (!halted && scan_ph <= PH_CODE) begin
            if (it.command) begin
                if (scan_ph <= PH_HDR3) begin
                    reject_stream();
                end else begin
                    // Flush held zeros; a pending 00 00 01 is dropped
                    if (scan_ph == PH_ZERO2) emit_obj_byte(BYTE_ZERO, 1'b0);
                    if (scan_ph == PH_ZERO1 || scan_ph == PH_ZERO2)
                        emit_obj_byte(BYTE_ZERO, 1'b0);
                    emit_end_marker();
                    halted  = 1'b1;
                    scan_ph = PH_HALT;
                end
            end else begin
                case (scan_ph)
                    PH_HDR0, PH_HDR1: begin
                        if (b != BYTE_ZERO) reject_stream();
                        else scan_ph = scan_ph + 1'b1;
                    end
                    PH_HDR2: begin
                        if (b != BYTE_ONE) reject_stream();
                        else scan_ph = PH_HDR3;
                    end
                    PH_HDR3: begin
                        open_object(b);
                        scan_ph = PH_BODY;
                    end
                    PH_BODY: begin
                        if (b == BYTE_ZERO) scan_ph = PH_ZERO1;
                        else emit_obj_byte(b, 1'b0);
                    end
                    PH_ZERO1: begin
                        if (b == BYTE_ZERO) begin
                            scan_ph = PH_ZERO2;
                        end else begin
                            emit_obj_byte(BYTE_ZERO, 1'b0);
                            emit_obj_byte(b, 1'b0);
                            scan_ph = PH_BODY;
                        end
                    end
                    PH_ZERO2: begin
                        if (b == BYTE_ONE) begin
                            scan_ph = PH_CODE;
                        end else begin
                            // Any byte but 01 releases the held pair
                            emit_obj_byte(BYTE_ZERO, 1'b0);
                            emit_obj_byte(BYTE_ZERO, 1'b0);
                            emit_obj_byte(b, 1'b0);
                            scan_ph = PH_BODY;
                        end
                    end
                    default: begin
                        emit_end_marker();
                        open_object(b);
                        scan_ph = PH_BODY;
                    end
                endcase
            end
        end
        if (step_q.size() > 0) begin
            t = step_q.pop_back();
            t.last = 1'b1;
            step_q.push_back(t);
            foreach (step_q[i]) pending_q.push_back(step_q[i]);
        end
    endtask

    // Drive one item, wait for the handshake, then idle for a random gap, possibly none
    task automatic send_item(input logic cmd, input logic [7:0] b);
        t_in_item it;
        int gap;
        it.command   = cmd;
        it.data_byte = b;
        @(negedge i_clk);
        in_valid <= 1'b1;
        in_item  <= it;
        do @(posedge i_clk); while (!in_if.ready);
        predict_split(it);
        n_sent++;
        gap = pick_gap();
        if (gap > 0) begin
            @(negedge i_clk);
            in_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
    endtask

    task automatic send_start_code(input logic [7:0] code);
        send_item(1'b0, BYTE_ZERO);
        send_item(1'b0, BYTE_ZERO);
        send_item(1'b0, BYTE_ONE);
        send_item(1'b0, code);
    endtask

    // Hold the sender until every predicted result has come out
    task automatic wait_drained();
        @(negedge i_clk);
        in_valid <= 1'b0;
        while (pending_q.size() > 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
            n_fail++;
        end
    endtask

    // Receiver stalls
    always @(negedge i_clk) begin
        static int stall = 0;
        if (stall > 0) begin
            out_ready <= 1'b0;
            stall--;
        end else begin
            out_ready <= 1'b1;
            if (!burst && $urandom_range(0, 3) == 0) stall = pick_gap();
        end
    end

    // Compare each result with the oldest prediction
    always @(posedge i_clk) begin
        t_out_item got;
        t_out_item want;
        if (i_rst_n && out_if.valid && out_ready) begin
            got = out_if.payload;
            n_results++;
            if (got.kind == KIND_MARKER) n_markers++;
            if (got.kind == KIND_ERROR) n_errors++;
            if (pending_q.size() == 0) begin
                $display("%0t: unexpected result, actual %0h", $time, got);
                n_fail++;
            end else begin
                want = pending_q.pop_front();
                check_field("kind", 16'(want.kind), 16'(got.kind));
                check_field("out_byte", 16'(want.out_byte), 16'(got.out_byte));
                check_field("object_start", 16'(want.object_start),
                            16'(got.object_start));
                check_field("object_code", 16'(want.object_code), 16'(got.object_code));
                check_field("is_config", 16'(want.is_config), 16'(got.is_config));
                check_field("is_vop", 16'(want.is_vop), 16'(got.is_vop));
                check_field("coding_type", 16'(want.coding_type), 16'(got.coding_type));
                check_field("object_length", want.object_length, got.object_length);
                check_field("config_before_first_vop", 16'(want.config_before_first_vop),
                            16'(got.config_before_first_vop));
                check_field("last", 16'(want.last), 16'(got.last));
            end
        end
    end

    // Open the stream; now and then break the header instead
    task automatic test_header();
        int pos;
        if ($urandom_range(0, 7) != 0) begin
            send_start_code(CODE_VOS);
            return;
        end
        pos = $urandom_range(0, 3);
        if (pos > 0) send_item(1'b0, BYTE_ZERO);
        if (pos > 1) send_item(1'b0, BYTE_ZERO);
        if (pos > 2) send_item(1'b0, BYTE_ONE);
        if (pos == 3 || $urandom_range(0, 1) == 0)
            send_item(1'b1, 8'($urandom_range(0, 255)));
        else if (pos == 2)
            send_item(1'b0, 8'($urandom_range(2, 255)));
        else
            send_item(1'b0, 8'($urandom_range(1, 255)));
    endtask

    // Byte extremes, held zeros, three zeros then 01, VOP coding types
    task automatic test_directed();
        logic [7:0] seq[$];
        seq = '{8'hFF, 8'h01,
                8'h00, 8'h7F,
                8'h00, 8'h00, 8'h80,
                8'h00, 8'h00, 8'h00, 8'h01,
                8'h00, 8'h00, 8'h01, CODE_VOP, 8'h40,
                8'h00, 8'h00, 8'h01, CODE_VL_LAST, 8'hAA,
                8'h00, 8'h00, 8'h01, CODE_VOP, 8'hC0};
        foreach (seq[i]) send_item(1'b0, seq[i]);
    endtask

    // One longer object, sent back to back
    task automatic test_long_object();
        burst = 1'b1;
        send_start_code(CODE_VO);
        repeat (LONG_BODY) send_item(1'b0, 8'($urandom_range(1, 255)));
        burst = 1'b0;
    endtask

    function automatic logic [7:0] pick_code();
        case ($urandom_range(0, 10))
            0: return CODE_VOS;
            1: return CODE_VO;
            2, 3: return CODE_VOP;
            4: return BYTE_ZERO;
            5: return CODE_VOL_LAST;
            6: return CODE_VL_FIRST;
            7: return CODE_VL_LAST;
            8: return 8'h30;
            9: return 8'hFF;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic logic [7:0] pick_body_byte();
        int r;
        r = $urandom_range(0, 99);
        if (r < 30) return BYTE_ZERO;
        if (r < 40) return BYTE_ONE;
        return 8'($urandom_range(0, 255));
    endfunction

    // Mostly whole objects with random bodies, some loose zero runs
    task automatic test_random();
        int start_cnt;
        int len;
        wait_drained();
        start_cnt = n_sent;
        while (n_sent - start_cnt < RAND_ITEMS) begin
            if ($urandom_range(0, 9) == 0) wait_drained();
            if ($urandom_range(0, 7) == 0) begin
                len = $urandom_range(1, 4);
                repeat (len) send_item(1'b0, ($urandom_range(0, 1) == 0) ?
                                       BYTE_ZERO : pick_body_byte());
            end else begin
                send_start_code(pick_code());
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 40)
                                                  : $urandom_range(0, 10);
                repeat (len) send_item(1'b0, pick_body_byte());
            end
        end
    endtask

    // Close the stream with a random tail, then send items that must be dropped
    task automatic test_end_of_stream();
        int tail;
        tail = $urandom_range(0, 3);
        if (tail > 0) send_item(1'b0, BYTE_ZERO);
        if (tail > 1) send_item(1'b0, BYTE_ZERO);
        if (tail > 2) send_item(1'b0, BYTE_ONE);
        send_item(1'b1, 8'($urandom_range(0, 255)));
        repeat (6) send_item(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
    endtask

    initial begin
        in_valid   = 1'b0;
        in_item    = '0;
        i_rst_n    = 1'b0;
        scan_ph    = PH_HDR0;
        cur_code   = BYTE_ZERO;
        obj_len    = '0;
        vop_coding = 3'd0;
        vop_begun  = 1'b0;
        halted     = 1'b0;
        n_fail     = 0;
        n_sent     = 0;
        n_results  = 0;
        n_markers  = 0;
        n_errors   = 0;
        burst      = 1'b0;
        repeat (10) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_header();
        test_directed();
        test_long_object();
        test_random();
        test_end_of_stream();
        wait_drained();

        $display("Sent %0d items; checked %0d results, %0d end markers, %0d header errors.",
                 n_sent, n_results, n_markers, n_errors);
        if (n_fail == 0 && pending_q.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #(TIMEOUT_NS);
        $display("CHECK FAILED");
        $finish;
    end

endmodule
